// ----- src/uer_pkg.sv -----
// Shared constants and types for the ultrasonic echo ranger.
// Used by uer_div and ultrasonic_echo_ranger_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

  // Register field widths.
  localparam int TRIG_W   = 8;
  localparam int ROUNDS_W = 4;
  localparam int GAP_W    = 20;
  localparam int TPC_W    = 8;
  localparam int CFG_W    = 20;
  localparam int CFG_IDX_W = 2;
  localparam int DIST_W   = 20;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROUNDS        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_CM  = 2'd3;

  // Register reset values.
  localparam logic [TRIG_W-1:0]   TRIGGER_TICKS_RST = 8'd20;
  localparam logic [ROUNDS_W-1:0] ROUNDS_RST        = 4'd5;
  localparam logic [GAP_W-1:0]    GAP_TICKS_RST     = 20'd50000;
  localparam logic [TPC_W-1:0]    TICKS_PER_CM_RST  = 8'd58;

  // Parameter defaults.
  localparam int MAX_ROUNDS_DEF = 8;
  localparam int WIDTH_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 4;

  // Divider status seen by the controller.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ----- src/uer_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on uer_pkg for the status struct.
`timescale 1ns / 1ps
`default_nettype none

module uer_div #(
  parameter int DVD_W = 24,
  parameter int DVS_W = 12
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output uer_pkg::div_stat_t    stat,
  output logic      [DVD_W-1:0] quotient
);
  import uer_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] count_r;
  logic             busy_r;
  logic             done_r;

  logic [DVS_W:0]   rem_shift;
  logic [DVS_W:0]   diff;
  logic             ge;

  always_comb begin
    rem_shift = {rem_r, quo_r[DVD_W-1]};
    diff      = rem_shift - {1'b0, dvs_r};
    ge        = (rem_shift >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      count_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r   <= dividend;
        rem_r   <= '0;
        dvs_r   <= divisor;
        count_r <= CNT_W'(DVD_W);
        busy_r  <= 1'b1;
      end else if (busy_r) begin
        quo_r   <= {quo_r[DVD_W-2:0], ge};
        rem_r   <= ge ? diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
        count_r <= count_r - 1'b1;
        if (count_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

`default_nettype wire

// ----- src/ultrasonic_echo_ranger_core.sv -----
// Ultrasonic time-of-flight ranging controller, one item per microsecond tick.
// Most items produce their result one cycle after acceptance and a new item may
// be taken every cycle; the item that closes a sequence waits for the shared
// divider, and no new item is taken until that result is registered.
// Reset (rst_n, synchronous, active low) restores register defaults and idles.
// Depends on uer_pkg and uer_div.
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_echo_ranger_core #(
  parameter int MAX_ROUNDS = uer_pkg::MAX_ROUNDS_DEF,
  parameter int WIDTH_BITS = uer_pkg::WIDTH_BITS_DEF,
  parameter int FRAC_BITS  = uer_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Tick items in.
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_start_req,
  input  wire logic                          in_echo,
  // Results out.
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_trigger,
  output logic                               out_busy_res,
  output logic                               out_done_res,
  output logic [uer_pkg::DIST_W-1:0]         out_distance_q4,
  // Configuration writes.
  input  wire logic                          cfg_we,
  input  wire logic [uer_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [uer_pkg::CFG_W-1:0]     cfg_data
);
  import uer_pkg::*;

  // The running sum holds at most fifteen saturated widths, hence four extra bits.
  localparam int SUM_W  = WIDTH_BITS + ROUNDS_W;
  localparam int DVD_W  = SUM_W + FRAC_BITS;
  localparam int DVS_W  = ROUNDS_W + TPC_W;
  localparam int WIDE_W = DVD_W + DIST_W;

  // Measurement phases.
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_TRIG = 3'd1;
  localparam logic [2:0] PH_WAIT = 3'd2;
  localparam logic [2:0] PH_MEAS = 3'd3;
  localparam logic [2:0] PH_GAP  = 3'd4;

  // Configuration registers.
  logic [TRIG_W-1:0]   trigger_ticks_r;
  logic [ROUNDS_W-1:0] rounds_r;
  logic [GAP_W-1:0]    gap_ticks_r;
  logic [TPC_W-1:0]    ticks_per_cm_r;

  // Sequencer state.
  logic [2:0]            phase_r,       phase_nxt;
  logic [GAP_W-1:0]      tick_count_r,  tick_count_nxt;
  logic [WIDTH_BITS-1:0] echo_width_r,  echo_width_nxt;
  logic [SUM_W-1:0]      width_sum_r,   width_sum_nxt;
  logic [ROUNDS_W-1:0]   rounds_done_r, rounds_done_nxt;
  logic [DIST_W-1:0]     last_dist_r;
  logic                  div_pend_r;

  // Output register.
  logic                  out_valid_r;
  logic                  out_trigger_r;
  logic                  out_busy_r;
  logic                  out_done_r;
  logic [DIST_W-1:0]     out_dist_r;

  logic                  accept;
  logic                  trig_c;
  logic                  final_c;
  logic                  gap_end_c;
  logic [ROUNDS_W-1:0]   eff_rounds;
  logic [TPC_W-1:0]      eff_tpc;
  logic [DVS_W-1:0]      divisor;
  logic [DVD_W-1:0]      dividend;

  div_stat_t             div_stat;
  logic [DVD_W-1:0]      quotient;
  logic [WIDE_W-1:0]     q_wide;
  logic [DIST_W-1:0]     dist_sat;

  // A new item is taken unless the divider is still working on the closing item
  // or a result is stalled; a result taken in the same cycle frees the register.
  assign in_ready = !div_pend_r && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  // Out-of-range register values are mapped onto their nearest legal meaning.
  always_comb begin
    if (rounds_r == '0) begin
      eff_rounds = ROUNDS_W'(1);
    end else if ({1'b0, rounds_r} > (ROUNDS_W + 1)'(MAX_ROUNDS)) begin
      eff_rounds = ROUNDS_W'(MAX_ROUNDS);
    end else begin
      eff_rounds = rounds_r;
    end
    eff_tpc = (ticks_per_cm_r == '0) ? TPC_W'(1) : ticks_per_cm_r;
  end

  // The product is at most 15 x 255, a small multiplier ahead of the divider.
  assign divisor  = DVS_W'(eff_rounds) * DVS_W'(eff_tpc);
  assign dividend = DVD_W'(width_sum_nxt) << FRAC_BITS;

  // Tick behaviour for the item being offered. final_c marks the tick that ends
  // the last gap; its distance comes from the divider once the division is done.
  always_comb begin
    phase_nxt       = phase_r;
    tick_count_nxt  = tick_count_r;
    echo_width_nxt  = echo_width_r;
    width_sum_nxt   = width_sum_r;
    rounds_done_nxt = rounds_done_r;
    trig_c          = 1'b0;
    gap_end_c       = 1'b0;
    final_c         = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (in_start_req) begin
          phase_nxt       = PH_TRIG;
          tick_count_nxt  = '0;
          echo_width_nxt  = '0;
          width_sum_nxt   = '0;
          rounds_done_nxt = '0;
        end
      end
      PH_TRIG: begin
        trig_c         = 1'b1;
        tick_count_nxt = tick_count_r + 1'b1;
        if (tick_count_nxt >= GAP_W'(trigger_ticks_r)) begin
          phase_nxt      = PH_WAIT;
          tick_count_nxt = '0;
        end
      end
      PH_WAIT: begin
        if (in_echo) begin
          phase_nxt      = PH_MEAS;
          echo_width_nxt = WIDTH_BITS'(1);
        end
      end
      PH_MEAS: begin
        if (in_echo) begin
          if (echo_width_r != '1) begin
            echo_width_nxt = echo_width_r + 1'b1;
          end
        end else begin
          width_sum_nxt   = width_sum_r + SUM_W'(echo_width_r);
          rounds_done_nxt = rounds_done_r + 1'b1;
          phase_nxt       = PH_GAP;
          tick_count_nxt  = '0;
          gap_end_c       = (gap_ticks_r == '0);
        end
      end
      PH_GAP: begin
        tick_count_nxt = tick_count_r + 1'b1;
        gap_end_c      = (tick_count_nxt >= gap_ticks_r);
      end
      default: begin
        phase_nxt      = PH_IDLE;
        tick_count_nxt = '0;
      end
    endcase
    // End of a gap: either the next round or the closing division.
    if (gap_end_c) begin
      tick_count_nxt = '0;
      if (rounds_done_nxt >= eff_rounds) begin
        phase_nxt = PH_IDLE;
        final_c   = 1'b1;
      end else begin
        phase_nxt = PH_TRIG;
      end
    end
  end

  uer_div #(
    .DVD_W(DVD_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept && final_c),
    .dividend (dividend),
    .divisor  (divisor),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // Quotients beyond the distance field saturate at its full-scale value.
  assign q_wide   = WIDE_W'(quotient);
  assign dist_sat = (|q_wide[WIDE_W-1:DIST_W]) ? '1 : q_wide[DIST_W-1:0];

  // Configuration registers; the user must write only while the block is idle, which the block itself does not enforce.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_ticks_r <= TRIGGER_TICKS_RST;
      rounds_r        <= ROUNDS_RST;
      gap_ticks_r     <= GAP_TICKS_RST;
      ticks_per_cm_r  <= TICKS_PER_CM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRIGGER_TICKS: trigger_ticks_r <= cfg_data[TRIG_W-1:0];
        REG_ROUNDS:        rounds_r        <= cfg_data[ROUNDS_W-1:0];
        REG_GAP_TICKS:     gap_ticks_r     <= cfg_data[GAP_W-1:0];
        REG_TICKS_PER_CM:  ticks_per_cm_r  <= cfg_data[TPC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer state and output register. An accepted item and a finishing
  // division never meet in one cycle, since the input is held off meanwhile.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      tick_count_r  <= '0;
      echo_width_r  <= '0;
      width_sum_r   <= '0;
      rounds_done_r <= '0;
      last_dist_r   <= '0;
      div_pend_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      out_trigger_r <= 1'b0;
      out_busy_r    <= 1'b0;
      out_done_r    <= 1'b0;
      out_dist_r    <= '0;
    end else begin
      if (accept) begin
        phase_r       <= phase_nxt;
        tick_count_r  <= tick_count_nxt;
        echo_width_r  <= echo_width_nxt;
        width_sum_r   <= width_sum_nxt;
        rounds_done_r <= rounds_done_nxt;
        out_trigger_r <= trig_c;
        out_busy_r    <= (phase_nxt != PH_IDLE);
        out_done_r    <= final_c;
        if (final_c) begin
          // The result is held back until the divider has finished.
          div_pend_r  <= 1'b1;
          out_valid_r <= 1'b0;
        end else begin
          out_dist_r  <= last_dist_r;
          out_valid_r <= 1'b1;
        end
      end else if (div_pend_r && div_stat.done) begin
        last_dist_r <= dist_sat;
        out_dist_r  <= dist_sat;
        out_valid_r <= 1'b1;
        div_pend_r  <= 1'b0;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_trigger     = out_trigger_r;
  assign out_busy_res    = out_busy_r;
  assign out_done_res    = out_done_r;
  assign out_distance_q4 = out_dist_r;

endmodule

`default_nettype wire

// ----- bench/ultrasonic_echo_ranger_core_tb.sv -----
// Self-checking testbench for ultrasonic_echo_ranger_core: tick items in, one result per tick out.
// A queue-fed driver and a scoreboarding monitor check every result against a predictor.
// Depends on uer_pkg and the ranger RTL only.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_core_tb;
  import uer_pkg::*;

  localparam int unsigned ECHO_SAT = (1 << WIDTH_BITS_DEF) - 1;
  localparam logic [DIST_W-1:0] DIST_SAT = '1;
  // The closing tick of a sequence waits for the divider; allow well beyond it.
  localparam int SETTLE_CYCLES = 40;

  typedef enum logic [2:0] {RP_IDLE, RP_TRIG, RP_WAIT, RP_MEAS, RP_GAP} ranger_phase_e;

  typedef struct packed {
    logic start;
    logic echo;
  } tick_item_t;

  typedef struct packed {
    logic              trigger;
    logic              busy;
    logic              done;
    logic [DIST_W-1:0] dist_q4;
  } ranger_res_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_start_req = 1'b0;
  logic                 in_echo = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_trigger;
  logic                 out_busy_res;
  logic                 out_done_res;
  logic [DIST_W-1:0]    out_distance_q4;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TRIGGER_TICKS;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Tick items waiting to be driven, and the results they are expected to produce.
  tick_item_t  tick_q[$];
  ranger_res_t res_q[$];

  // The predictor's copy of the registers and of the ranging state.
  logic [TRIG_W-1:0]   reg_trig;
  logic [ROUNDS_W-1:0] reg_rounds;
  logic [GAP_W-1:0]    reg_gap;
  logic [TPC_W-1:0]    reg_tpc;
  ranger_phase_e       pr_phase;
  int unsigned         pr_ticks;
  int unsigned         pr_width;
  longint unsigned     pr_sum;
  logic [3:0]          pr_rounds_done;
  logic [DIST_W-1:0]   pr_distance;

  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int n_pushed = 0;
  int n_items = 0;
  int n_checked = 0;
  int n_distances = 0;
  int n_writes = 0;
  int n_fail = 0;

  ultrasonic_echo_ranger_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_start_req   (in_start_req),
    .in_echo        (in_echo),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_trigger    (out_trigger),
    .out_busy_res   (out_busy_res),
    .out_done_res   (out_done_res),
    .out_distance_q4(out_distance_q4),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // A rounds register of zero acts as one round, anything above the maximum as the maximum.
  function automatic int unsigned rounds_in_use();
    if (reg_rounds == 0) return 1;
    if (reg_rounds > MAX_ROUNDS_DEF) return MAX_ROUNDS_DEF;
    return int'(reg_rounds);
  endfunction

  // End of a gap: either another round begins, or the mean distance is stored and the
  // ranger goes idle. Returns 1 when a distance has been stored.
  function automatic logic finish_round();
    longint unsigned divisor;
    longint unsigned quot;
    pr_ticks = 0;
    if (pr_rounds_done >= rounds_in_use()) begin
      divisor = rounds_in_use() * ((reg_tpc == 0) ? 1 : int'(reg_tpc));
      quot = (pr_sum << FRAC_BITS_DEF) / divisor;
      pr_distance = (quot > DIST_SAT) ? DIST_SAT : quot[DIST_W-1:0];
      pr_phase = RP_IDLE;
      return 1'b1;
    end
    pr_phase = RP_TRIG;
    return 1'b0;
  endfunction

  // Advances the predicted ranger by one tick and returns the result that tick should give.
  function automatic ranger_res_t advance_ranger(input logic start, input logic echo);
    ranger_res_t r;
    r.trigger = 1'b0;
    r.done = 1'b0;
    case (pr_phase)
      RP_IDLE: begin
        if (start) begin
          pr_phase = RP_TRIG;
          pr_ticks = 0;
          pr_width = 0;
          pr_sum = 0;
          pr_rounds_done = '0;
        end
      end
      RP_TRIG: begin
        // A trigger length of zero still gives one trigger tick.
        r.trigger = 1'b1;
        pr_ticks++;
        if (pr_ticks >= reg_trig) begin
          pr_phase = RP_WAIT;
          pr_ticks = 0;
        end
      end
      RP_WAIT: begin
        if (echo) begin
          pr_phase = RP_MEAS;
          pr_width = 1;
        end
      end
      RP_MEAS: begin
        if (echo) begin
          if (pr_width < ECHO_SAT) pr_width++;
        end else begin
          pr_sum += pr_width;
          pr_rounds_done = pr_rounds_done + 1'b1;
          pr_phase = RP_GAP;
          pr_ticks = 0;
          // With no gap the round closes on the very tick that the echo falls.
          if (reg_gap == 0) r.done = finish_round();
        end
      end
      RP_GAP: begin
        pr_ticks++;
        if (pr_ticks >= reg_gap) r.done = finish_round();
      end
      default: begin
        pr_phase = RP_IDLE;
        pr_ticks = 0;
      end
    endcase
    r.busy = (pr_phase != RP_IDLE);
    r.dist_q4 = pr_distance;
    return r;
  endfunction

  // Driver: predicts each accepted item, then offers the next queued item unless the
  // sender is idling this cycle.
  always @(posedge clk) begin : tick_driver
    tick_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        res_q.push_back(advance_ranger(in_start_req, in_echo));
        n_items++;
      end
      if (!in_valid || in_ready) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          nxt = tick_q.pop_front();
          in_valid <= 1'b1;
          in_start_req <= nxt.start;
          in_echo <= nxt.echo;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: each accepted result is held against the oldest expectation, field by field.
  always @(posedge clk) begin : result_monitor
    ranger_res_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (res_q.size() == 0) begin
          $error("result accepted with no tick item outstanding");
          n_fail++;
        end else begin
          want = res_q.pop_front();
          n_checked++;
          if (out_trigger !== want.trigger) begin
            $error("trigger: expected %0b, got %0b", want.trigger, out_trigger);
            n_fail++;
          end
          if (out_busy_res !== want.busy) begin
            $error("busy_res: expected %0b, got %0b", want.busy, out_busy_res);
            n_fail++;
          end
          if (out_done_res !== want.done) begin
            $error("done_res: expected %0b, got %0b", want.done, out_done_res);
            n_fail++;
          end
          if (out_distance_q4 !== want.dist_q4) begin
            $error("distance_q4: expected %0d, got %0d", want.dist_q4, out_distance_q4);
            n_fail++;
          end
          if (want.done) n_distances++;
        end
      end
      out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  task automatic push_tick(input logic start, input logic echo);
    tick_item_t it;
    it.start = start;
    it.echo = echo;
    tick_q.push_back(it);
    n_pushed++;
  endtask

  // Queues one well-formed measurement from idle under the current registers: the start
  // tick, then per round the trigger ticks, a few ticks before the echo rises, an echo of
  // the chosen width, its falling tick and the gap. Start requests are sprinkled over the
  // busy ticks, where they must be ignored.
  task automatic push_sequence(input int wait_max, input int width_lo, input int width_hi);
    int trig_len;
    int n;
    trig_len = (reg_trig == 0) ? 1 : int'(reg_trig);
    push_tick(1'b1, 1'($urandom_range(1)));
    for (int r = 0; r < rounds_in_use(); r++) begin
      for (int i = 0; i < trig_len; i++) begin
        push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      n = $urandom_range(wait_max);
      for (int i = 0; i < n; i++) push_tick(1'($urandom_range(1)), 1'b0);
      n = $urandom_range(width_hi, width_lo);
      for (int i = 0; i < n; i++) push_tick(1'($urandom_range(1)), 1'b1);
      push_tick(1'($urandom_range(1)), 1'b0);
      for (int i = 0; i < reg_gap; i++) begin
        push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  // Brings the ranger back to idle and lets every result arrive. Any sequence still
  // running is steered to its end: echo is raised while waiting and dropped while
  // measuring, since there is no echo timeout.
  task automatic settle_idle();
    @(negedge clk);
    forever begin
      while (tick_q.size() != 0 || in_valid) @(negedge clk);
      if (pr_phase == RP_IDLE) break;
      case (pr_phase)
        RP_WAIT: push_tick(1'($urandom_range(1)), 1'b1);
        RP_MEAS: push_tick(1'($urandom_range(1)), 1'b0);
        default: push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
      endcase
    end
    while (res_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register writes happen only with the ranger idle and nothing in flight.
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_TRIGGER_TICKS: reg_trig = val[TRIG_W-1:0];
      REG_ROUNDS:        reg_rounds = val[ROUNDS_W-1:0];
      REG_GAP_TICKS:     reg_gap = val[GAP_W-1:0];
      REG_TICKS_PER_CM:  reg_tpc = val[TPC_W-1:0];
      default: ;
    endcase
    n_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [31:0]         junk;
    logic [TRIG_W-1:0]   t;
    logic [ROUNDS_W-1:0] rn;
    logic [GAP_W-1:0]    g;
    logic [TPC_W-1:0]    tp;
    int                  budget;

    reg_trig = TRIGGER_TICKS_RST;
    reg_rounds = ROUNDS_RST;
    reg_gap = GAP_TICKS_RST;
    reg_tpc = TICKS_PER_CM_RST;
    pr_phase = RP_IDLE;
    pr_ticks = 0;
    pr_width = 0;
    pr_sum = 0;
    pr_rounds_done = '0;
    pr_distance = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, with light idling on both sides. Idle ticks first: the stored
    // distance must read zero straight after reset.
    snd_idle_pct = 21;
    rcv_stall_pct = 21;
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b0);
    settle_idle();

    // Only the gap is shortened, so the reset values of the trigger length, the round
    // count and the scale are all exercised by this measurement.
    write_cfg(REG_GAP_TICKS, CFG_W'(3));
    push_sequence(2, 1, 8);
    settle_idle();

    // Every register at zero: one trigger tick, one round, no gap, unit scale.
    write_cfg(REG_TRIGGER_TICKS, CFG_W'(0));
    write_cfg(REG_ROUNDS, CFG_W'(0));
    write_cfg(REG_GAP_TICKS, CFG_W'(0));
    write_cfg(REG_TICKS_PER_CM, CFG_W'(0));
    push_sequence(2, 1, 8);
    settle_idle();

    // Upper extremes: a round count clamped to the maximum and the widest scale.
    write_cfg(REG_TRIGGER_TICKS, CFG_W'(6));
    write_cfg(REG_ROUNDS, CFG_W'(15));
    write_cfg(REG_GAP_TICKS, CFG_W'(1));
    write_cfg(REG_TICKS_PER_CM, CFG_W'(255));
    push_sequence(0, 1, 4);
    settle_idle();

    // The longest gap is written but only idle ticks follow; a sequence under it would
    // last a million ticks.
    write_cfg(REG_GAP_TICKS, 20'hFFFFF);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b0);
    settle_idle();

    // Random part: four idling patterns, two register settings in each. Mostly complete
    // measurements with random content; the rest are bursts of random ticks, which may
    // start sequences that are then left to run on.
    for (int m = 0; m < 4; m++) begin
      case (m)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 84; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 84; end
        default: begin snd_idle_pct = 21; rcv_stall_pct = 21; end
      endcase
      for (int s = 0; s < 2; s++) begin
        junk = $urandom();
        t = TRIG_W'($urandom_range(4));
        // Round counts are mostly small; now and then the full register range is used.
        rn = ($urandom_range(3) == 0) ? ROUNDS_W'($urandom_range(15)) :
                                        ROUNDS_W'($urandom_range(3));
        g = GAP_W'($urandom_range(4));
        case ($urandom_range(3))
          0: tp = '0;
          1: tp = TPC_W'(1);
          2: tp = '1;
          default: tp = TPC_W'($urandom_range(254, 2));
        endcase
        // Bits above a register's width are filled with junk; the block must drop them.
        write_cfg(REG_TRIGGER_TICKS, {junk[19:8], t});
        write_cfg(REG_ROUNDS, {junk[31:16], rn});
        write_cfg(REG_GAP_TICKS, g);
        write_cfg(REG_TICKS_PER_CM, {junk[11:0], tp});
        budget = n_pushed + 20;
        while (n_pushed < budget) begin
          if ($urandom_range(99) < 80) begin
            push_sequence(2, 1, 8);
          end else begin
            repeat ($urandom_range(10, 2)) begin
              push_tick($urandom_range(3) == 0, 1'($urandom_range(1)));
            end
            settle_idle();
          end
        end
        settle_idle();
      end
    end

    $display("Run covered %0d tick items and %0d checked results, %0d of them distances.",
             n_items, n_checked, n_distances);
    $display("%0d register writes across the settings; %0d mismatches seen.", n_writes, n_fail);
    if (n_fail == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Guard against a hung handshake: several times the slowest expected run.
  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule
